// ===== sv/nmc_pkg.sv =====
// ---------------------------------------------------------------------------
// nmc_pkg
// Shared types, register indexes and helpers for the neighbourhood mark
// counter.
// ---------------------------------------------------------------------------
package nmc_pkg;

   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_ROWS    = 1024;

   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 4;
   localparam int COL_CNT_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // window columns held in the chain, the newest column comes straight in
   localparam int WINDOW_CELLS    = 2;
   localparam int RSP_QUEUE_DEPTH = 8;

   localparam logic [CHAR_W-1:0] MARK_SYMBOL_RESET = 8'd33;

   localparam logic [CSR_IDX_W-1:0] CSR_MARK_SYMBOL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS_IN_USE = 2'd2;

   localparam logic CMD_CELL  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic              command;
      logic [CHAR_W-1:0] cell_char;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] mark_count;
      logic               row_end;
      logic               frame_end;
      logic               last_of_burst;
   } rsp_type;

   // one column of the 3x3 window: rows r-2, r-1 and r
   typedef struct packed {
      logic top;
      logic mid;
      logic bot;
   } col_type;

   // line store word: mark of the older row and of the newer row
   typedef struct packed {
      logic older;
      logic newer;
   } line_type;

   // up to two results per beat into the result queue
   typedef struct packed {
      logic    valid_a;
      rsp_type data_a;
      logic    valid_b;
      rsp_type data_b;
   } push_type;

   function automatic logic [COL_CNT_W-1:0] col_count(input col_type c);
      col_count = COL_CNT_W'(c.top) + COL_CNT_W'(c.mid) + COL_CNT_W'(c.bot);
   endfunction

endpackage

// ===== sv/nmc_ram.sv =====
// ---------------------------------------------------------------------------
// nmc_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module nmc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = nmc_pkg::DEF_MAX_COLUMNS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/nmc_cell.sv =====
// ---------------------------------------------------------------------------
// nmc_cell
// One column cell of the window chain: takes its neighbour's column on each
// beat, or an empty column at the start of a row.
// ---------------------------------------------------------------------------
module nmc_cell (
   input  logic             clock,
   input  logic             shift,
   input  logic             wipe,
   input  nmc_pkg::col_type col_in,
   output nmc_pkg::col_type col_out
);

   nmc_pkg::col_type col_ff;
   nmc_pkg::col_type col_in_sel;

   assign col_in_sel = wipe ? '0 : col_in;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in_sel;
      end
   end

   assign col_out = col_ff;

endmodule

// ===== sv/nmc_rsp_queue.sv =====
// ---------------------------------------------------------------------------
// nmc_rsp_queue
// Result queue taking up to two results per cycle and handing out one beat
// per cycle on the result channel while rsp_ready is high.
// ---------------------------------------------------------------------------
module nmc_rsp_queue #(
   parameter int DEPTH = nmc_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  nmc_pkg::push_type          push,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output nmc_pkg::rsp_type           rsp_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   nmc_pkg::rsp_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  addr_b;
   logic [1:0]        push_n;
   logic              pop;

   assign push_n = {1'b0, push.valid_a} + {1'b0, push.valid_b};
   assign pop    = rsp_valid && rsp_ready;
   // second result lands behind the first when both come
   assign addr_b = push.valid_a ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         mem_ff[wr_ptr_ff] <= push.data_a;
      end
      if (push.valid_b) begin
         mem_ff[addr_b] <= push.data_b;
      end
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== sv/neighbourhood_mark_counter.sv =====
// ---------------------------------------------------------------------------
// neighbourhood_mark_counter
// Counts marked cells in the 3x3 neighbourhood of every cell of a raster
// stream, using a line store and a short chain of window column cells.
// ---------------------------------------------------------------------------
// results: a beat's results are formed in the second stage and pushed into
//   the eight-entry result queue, which hands them out on rsp in order
// throughput: one beat per cycle; a last-column beat gives two results;
//   req_ready drops once the queue, with results on their way in, has room for fewer than two more
// reset: positions cleared, registers back to '!', one row, one column;
//   the line store needs no clearing pass, unwritten columns are masked
module neighbourhood_mark_counter #(
   parameter int MAX_COLUMNS = nmc_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = nmc_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  nmc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output nmc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [nmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nmc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W   = $clog2(MAX_COLUMNS);
   localparam int ROW_W   = $clog2(MAX_ROWS + 1);
   localparam int Q_DEPTH = nmc_pkg::RSP_QUEUE_DEPTH;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
   localparam int LINE_W  = $bits(nmc_pkg::line_type);
   localparam int CELLS   = nmc_pkg::WINDOW_CELLS;

   // configuration and position
   logic [nmc_pkg::CHAR_W-1:0] mark_symbol_ff, mark_symbol_in;
   logic [ROW_W-1:0]           rows_ff, rows_in;
   logic [COL_W-1:0]           cols_last_ff, cols_last_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic [ROW_W-1:0]           rows_clamped;
   logic [COL_W-1:0]           cols_last_clamped;

   // second stage
   logic                       s1_valid_ff;
   logic [COL_W-1:0]           s1_addr_ff;
   logic                       s1_first_col_ff;
   logic                       s1_last_col_ff;
   logic                       s1_ge1_ff;
   logic                       s1_ge2_ff;
   logic                       s1_drain_ff;
   logic                       s1_mark_ff;
   logic                       byp_hit_ff;
   nmc_pkg::line_type          byp_data_ff;

   logic                       req_accept;
   logic                       is_cell;
   logic                       grid_full;
   logic                       col_last;
   logic                       item_live;

   nmc_pkg::line_type          ram_rdata;
   nmc_pkg::line_type          ram_wdata;
   nmc_pkg::line_type          line_rd;
   logic                       ram_we;

   nmc_pkg::col_type           link [CELLS+1];
   logic [nmc_pkg::COL_CNT_W-1:0] cnt_new, cnt_near, cnt_far;
   logic [nmc_pkg::COUNT_W-1:0]   sum_b, sum_a;

   nmc_pkg::push_type          push;
   logic [1:0]                 push_n;
   logic [Q_CNT_W-1:0]         q_count;
   logic [Q_CNT_W:0]           q_fill;
   logic [Q_CNT_W:0]           q_need;

   // ---------------- accept stage ----------------

   assign req_accept = req_valid && req_ready;
   assign is_cell    = req_data.command == nmc_pkg::CMD_CELL;
   assign grid_full  = row_ff == rows_ff;
   assign col_last   = col_ff == cols_last_ff;
   // cells after the grid and early drain beats are dropped here
   assign item_live  = req_accept && (is_cell ? !grid_full : grid_full);

   always_comb begin
      if (csr_wdata == '0) begin
         rows_clamped = ROW_W'(1);
      end else if (32'(csr_wdata) > MAX_ROWS) begin
         rows_clamped = ROW_W'(MAX_ROWS);
      end else begin
         rows_clamped = ROW_W'(csr_wdata);
      end
      if (csr_wdata == '0) begin
         cols_last_clamped = '0;
      end else if (32'(csr_wdata) > MAX_COLUMNS) begin
         cols_last_clamped = COL_W'(MAX_COLUMNS - 1);
      end else begin
         cols_last_clamped = COL_W'(csr_wdata - nmc_pkg::CSR_DATA_W'(1));
      end
   end

   always_comb begin
      mark_symbol_in = mark_symbol_ff;
      rows_in        = rows_ff;
      cols_last_in   = cols_last_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      if (item_live) begin
         if (col_last) begin
            col_in = '0;
            // last drain beat restarts the frame
            row_in = is_cell ? row_ff + ROW_W'(1) : '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      if (csr_we) begin
         case (csr_index)
            nmc_pkg::CSR_MARK_SYMBOL: begin
               mark_symbol_in = csr_wdata[nmc_pkg::CHAR_W-1:0];
            end
            nmc_pkg::CSR_ROWS_IN_USE: begin
               rows_in = rows_clamped;
               col_in  = '0;
               row_in  = '0;
            end
            nmc_pkg::CSR_COLUMNS_IN_USE: begin
               cols_last_in = cols_last_clamped;
               col_in       = '0;
               row_in       = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_symbol_ff <= nmc_pkg::MARK_SYMBOL_RESET;
         rows_ff        <= ROW_W'(1);
         cols_last_ff   <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         mark_symbol_ff <= mark_symbol_in;
         rows_ff        <= rows_in;
         cols_last_ff   <= cols_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         s1_valid_ff    <= item_live;
      end
   end

   always_ff @(posedge clock) begin
      if (item_live) begin
         s1_addr_ff      <= col_ff;
         s1_first_col_ff <= col_ff == '0;
         s1_last_col_ff  <= col_last;
         s1_ge1_ff       <= row_ff != '0;
         s1_ge2_ff       <= row_ff > ROW_W'(1);
         s1_drain_ff     <= !is_cell;
         s1_mark_ff      <= is_cell && (req_data.cell_char == mark_symbol_ff);
         // same column read back to back: take the word being written
         byp_hit_ff      <= ram_we && (col_ff == s1_addr_ff);
         byp_data_ff     <= ram_wdata;
      end
   end

   // ---------------- line store ----------------

   nmc_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_COLUMNS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wdata),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   // ---------------- window stage ----------------

   assign line_rd = byp_hit_ff ? byp_data_ff : ram_rdata;

   assign link[0].top = line_rd.older & s1_ge2_ff;
   assign link[0].mid = line_rd.newer & s1_ge1_ff;
   assign link[0].bot = s1_mark_ff;

   assign ram_we          = s1_valid_ff && !s1_drain_ff;
   assign ram_wdata.older = link[0].mid;
   assign ram_wdata.newer = s1_mark_ff;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      nmc_cell u_cell (
         .clock   (clock),
         .shift   (s1_valid_ff),
         .wipe    (s1_first_col_ff && (i != 0)),
         .col_in  (link[i]),
         .col_out (link[i+1])
      );
   end

   assign cnt_new  = nmc_pkg::col_count(link[0]);
   // left neighbour is outside the grid on the first column
   assign cnt_near = s1_first_col_ff ? '0 : nmc_pkg::col_count(link[1]);
   assign cnt_far  = nmc_pkg::col_count(link[2]);

   assign sum_b = nmc_pkg::COUNT_W'(cnt_new) + nmc_pkg::COUNT_W'(cnt_near);
   assign sum_a = sum_b + nmc_pkg::COUNT_W'(cnt_far);

   always_comb begin
      push.valid_a              = s1_valid_ff && s1_ge1_ff && !s1_first_col_ff;
      push.data_a.mark_count    = sum_a;
      push.data_a.row_end       = 1'b0;
      push.data_a.frame_end     = 1'b0;
      push.data_a.last_of_burst = !s1_last_col_ff;
      push.valid_b              = s1_valid_ff && s1_ge1_ff && s1_last_col_ff;
      push.data_b.mark_count    = sum_b;
      push.data_b.row_end       = 1'b1;
      push.data_b.frame_end     = s1_drain_ff;
      push.data_b.last_of_burst = 1'b1;
   end

   // ---------------- result queue ----------------

   nmc_rsp_queue #(
      .DEPTH (Q_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .count     (q_count)
   );

   assign push_n    = {1'b0, push.valid_a} + {1'b0, push.valid_b};
   assign q_fill    = {1'b0, q_count} + (Q_CNT_W+1)'(push_n);
   // room for this cycle's results and two more from the beat now accepted
   assign q_need    = q_fill + (Q_CNT_W+1)'(2);
   assign req_ready = q_need <= (Q_CNT_W+1)'(Q_DEPTH);

   // ---------------- assertions ----------------

   a_col_range : assert property (@(posedge clock) disable iff (reset)
      col_ff <= cols_last_ff)
      else $error("column position beyond last column");

   a_row_range : assert property (@(posedge clock) disable iff (reset)
      row_ff <= rows_ff)
      else $error("row position beyond grid");

   a_queue_room : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_fill <= (Q_CNT_W+1)'(Q_DEPTH)))
      else $error("result queue overflow");

   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      (push.valid_a && push.valid_b) |-> !push.data_a.last_of_burst)
      else $error("first of two results marked as last");

endmodule

// ===== tb/neighbourhood_mark_counter_checker.sv =====
// ---------------------------------------------------------------------------
// neighbourhood_mark_counter_checker
// Watches the cell, result and register ports of the mark counter, keeps its
// own copy of the line stores and raster position, and compares every result
// beat with the oldest window sum still awaited.
// ---------------------------------------------------------------------------
module neighbourhood_mark_counter_checker
   import nmc_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // marks of rows r-2, r-1 and the row coming in
   bit [MAX_COLUMNS-1:0]  older_marks;
   bit [MAX_COLUMNS-1:0]  prior_marks;
   bit [MAX_COLUMNS-1:0]  fresh_marks;
   int unsigned           col_at;
   int unsigned           row_at;
   int unsigned           drain_at;
   logic [CHAR_W-1:0]     symbol;
   logic [CSR_DATA_W-1:0] rows_set;
   logic [CSR_DATA_W-1:0] cols_set;
   rsp_type               awaited_sums[$];
   int                    errors = 0;

   function automatic int unsigned fit(int unsigned v, int unsigned ceiling);
      if (v < 1) return 1;
      if (v > ceiling) return ceiling;
      return v;
   endfunction

   function automatic int unsigned triple(bit [MAX_COLUMNS-1:0] line, bit ok,
                                          int unsigned cc, int unsigned cols);
      int unsigned s;
      s = 0;
      if (!ok) return 0;
      for (int k = -1; k <= 1; k++) begin
         if (int'(cc) + k >= 0 && int'(cc) + k < int'(cols)) s += line[int'(cc) + k];
      end
      return s;
   endfunction

   task automatic restart_frame();
      older_marks = '0;
      prior_marks = '0;
      fresh_marks = '0;
      col_at      = 0;
      row_at      = 0;
      drain_at    = 0;
   endtask

   task automatic post_window_sum(int unsigned rr, int unsigned cc, int unsigned rows,
                                  int unsigned cols, bit bot_ok);
      rsp_type sum;
      sum.mark_count    = COUNT_W'(triple(older_marks, rr > 0, cc, cols)
                                 + triple(prior_marks, 1'b1, cc, cols)
                                 + triple(fresh_marks, bot_ok && rr + 1 < rows, cc, cols));
      sum.row_end       = (cc == cols - 1);
      sum.frame_end     = (cc == cols - 1) && (rr == rows - 1);
      sum.last_of_burst = 1'b0;
      awaited_sums.push_back(sum);
   endtask

   task automatic advance_raster(req_type beat);
      int unsigned rows;
      int unsigned cols;
      int unsigned c;
      int unsigned r;
      int          queued;
      rows   = fit(rows_set, MAX_ROWS);
      cols   = fit(cols_set, MAX_COLUMNS);
      queued = awaited_sums.size();
      if (row_at > rows || col_at >= cols || drain_at >= cols) restart_frame();
      if (beat.command == CMD_CELL) begin
         c = col_at;
         r = row_at;
         // cell beyond the grid while the drain is pending
         if (r >= rows) return;
         fresh_marks[c] = (beat.cell_char == symbol);
         if (r >= 1) begin
            if (c >= 1) post_window_sum(r - 1, c - 1, rows, cols, 1'b1);
            if (c == cols - 1) post_window_sum(r - 1, cols - 1, rows, cols, 1'b1);
         end
         if (c == cols - 1) begin
            older_marks = prior_marks;
            prior_marks = fresh_marks;
            col_at      = 0;
            row_at      = r + 1;
         end else begin
            col_at = c + 1;
         end
      end else begin
         // drain before the last cell is ignored
         if (row_at < rows) return;
         if (drain_at >= 1) post_window_sum(rows - 1, drain_at - 1, rows, cols, 1'b0);
         if (drain_at == cols - 1) begin
            post_window_sum(rows - 1, cols - 1, rows, cols, 1'b0);
            restart_frame();
         end else begin
            drain_at++;
         end
      end
      if (awaited_sums.size() > queued)
         awaited_sums[awaited_sums.size() - 1].last_of_burst = 1'b1;
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (awaited_sums.size() == 0) begin
         $display("%0t: result beat with nothing awaited, got %p", $time, got);
         errors++;
         return;
      end
      want = awaited_sums.pop_front();
      if (got.mark_count !== want.mark_count) begin
         $display("%0t: mark_count expected %0d, got %0d", $time, want.mark_count,
                  got.mark_count);
         errors++;
      end
      if (got.row_end !== want.row_end) begin
         $display("%0t: row_end expected %0b, got %0b", $time, want.row_end, got.row_end);
         errors++;
      end
      if (got.frame_end !== want.frame_end) begin
         $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                  got.frame_end);
         errors++;
      end
      if (got.last_of_burst !== want.last_of_burst) begin
         $display("%0t: last_of_burst expected %0b, got %0b", $time, want.last_of_burst,
                  got.last_of_burst);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         symbol   = MARK_SYMBOL_RESET;
         rows_set = 1;
         cols_set = 1;
         restart_frame();
         awaited_sums.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (csr_we) begin
            case (csr_index)
               CSR_MARK_SYMBOL: begin
                  symbol = csr_wdata[CHAR_W-1:0];
               end
               CSR_ROWS_IN_USE: begin
                  rows_set = csr_wdata;
                  restart_frame();
               end
               CSR_COLUMNS_IN_USE: begin
                  cols_set = csr_wdata;
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) advance_raster(req_data);
      end
      fail_count  <= errors;
      outstanding <= awaited_sums.size();
   end

endmodule

// ===== tb/neighbourhood_mark_counter_test.sv =====
// ---------------------------------------------------------------------------
// neighbourhood_mark_counter_test
// Drives raster frames of many sizes and mark symbols into the mark counter,
// with bursty input, a stalling result side and one long hold-off, and leaves
// the prediction and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module neighbourhood_mark_counter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import nmc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_ITEMS  = 1950;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 240;

   typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_MOSTLY, DRAIN_SLOW} drain_style_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    outstanding;

   int                burst_left    = 0;
   bit                gapless       = 1'b0;
   bit                hold_request  = 1'b0;
   int                rows_eff      = 1;
   int                cols_eff      = 1;
   int                counted       = 0;
   logic [CHAR_W-1:0] cur_symbol    = MARK_SYMBOL_RESET;

   drain_style_type style      = DRAIN_FREE;
   int              style_left = 0;
   int              hold_left  = 0;
   bit              hold_done  = 1'b0;

   neighbourhood_mark_counter dut (.*);
   neighbourhood_mark_counter_checker watch (.*);

   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("** neighbourhood_mark_counter: FAILED **");
      $finish;
   end

   // result side: changing stall patterns, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            style      = drain_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(16, 160);
         end
         style_left--;
         case (style)
            DRAIN_FREE:   rsp_ready <= 1'b1;
            DRAIN_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            DRAIN_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
            default:      rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic send_beat(logic cmd, logic [CHAR_W-1:0] ch);
      if (burst_left == 0) begin
         if (!gapless) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, cell_char: ch};
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // stop offering and wait until every awaited result has come out
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(logic [CHAR_W-1:0] symbol, int rows_raw, int cols_raw);
      settle();
      write_reg(CSR_MARK_SYMBOL, CSR_DATA_W'(symbol));
      write_reg(CSR_ROWS_IN_USE, CSR_DATA_W'(rows_raw));
      write_reg(CSR_COLUMNS_IN_USE, CSR_DATA_W'(cols_raw));
      csr_we <= 1'b0;
      cur_symbol = symbol;
      rows_eff   = (rows_raw == 0) ? 1 : (rows_raw > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_raw);
      cols_eff   = (cols_raw == 0) ? 1 : (cols_raw > DEF_MAX_COLUMNS ? DEF_MAX_COLUMNS
                                                                     : cols_raw);
   endtask

   task automatic swap_symbol(logic [CHAR_W-1:0] symbol);
      settle();
      write_reg(CSR_MARK_SYMBOL, CSR_DATA_W'(symbol));
      csr_we <= 1'b0;
      cur_symbol = symbol;
   endtask

   function automatic logic [CHAR_W-1:0] any_symbol();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return MARK_SYMBOL_RESET;
         default: return CHAR_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char();
      return $urandom_range(0, 1) ? cur_symbol : CHAR_W'($urandom_range(0, 255));
   endfunction

   // one frame of cells then its drain; cut < 0 sends the whole frame, else it stops before cell cut
   task automatic run_frame(bit noisy, int cut);
      int total;
      total = rows_eff * cols_eff;
      for (int i = 0; i < total; i++) begin
         if (cut == i) return;
         if (noisy && $urandom_range(0, 19) == 0)
            send_beat(CMD_DRAIN, CHAR_W'($urandom));
         if ($urandom_range(0, 4 * total) == 0) swap_symbol(any_symbol());
         send_beat(CMD_CELL, pick_char());
         counted++;
      end
      for (int d = 0; d < cols_eff; d++) begin
         if (noisy && $urandom_range(0, 3) == 0) send_beat(CMD_CELL, pick_char());
         send_beat(CMD_DRAIN, CHAR_W'($urandom));
         counted++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // register defaults: a single cell marked by '!'
      send_beat(CMD_DRAIN, '1);
      send_beat(CMD_CELL, MARK_SYMBOL_RESET);
      send_beat(CMD_CELL, '0);
      send_beat(CMD_DRAIN, '0);

      settle();
      write_reg(CSR_SPARE, '1);
      csr_we <= 1'b0;
      configure('1, 3, 3);
      send_beat(CMD_CELL, '1);
      send_beat(CMD_CELL, '0);
      send_beat(CMD_CELL, '1);
      send_beat(CMD_CELL, '0);
      send_beat(CMD_CELL, '1);
      send_beat(CMD_CELL, '1);
      send_beat(CMD_CELL, '1);
      send_beat(CMD_CELL, '1);
      send_beat(CMD_CELL, '0);
      repeat (3) send_beat(CMD_DRAIN, '1);

      // tall frame at the row limit, sizes above range and zero, result side held
      configure(any_symbol(), 2047, 0);
      hold_request <= 1'b1;
      gapless = 1'b1;
      run_frame(1'b0, -1);
      gapless = 1'b0;

      // widest line, partly filled before the next size write restarts it
      configure(any_symbol(), 1024, 1024);
      run_frame(1'b1, 40);

      while (counted < RANDOM_ITEMS) begin
         configure(any_symbol(),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10));
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 6) == 0) begin
               run_frame(1'b1, $urandom_range(0, rows_eff * cols_eff - 1));
               break;
            end
            run_frame($urandom_range(0, 3) == 0, -1);
            if ($urandom_range(0, 4) == 0) swap_symbol(any_symbol());
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("** neighbourhood_mark_counter: PASSED **");
      end else begin
         $display("** neighbourhood_mark_counter: FAILED **");
      end
      $finish;
   end

endmodule
